[rtl/core/els_pkg.sv]
package els_pkg;

    // default building height
    localparam int NUM_FLOORS_DEF = 8;

    // field widths of the words on the channels
    localparam int MODE_W  = 2;
    localparam int FLOOR_W = 4;

    // command codes carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_REQUEST    = 2'd0,
        MODE_DOOR_CLOSE = 2'd1,
        MODE_TICK       = 2'd2
    } mode_t;

    typedef logic [FLOOR_W-1:0] floor_t;

    // one command word as held in the input register
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        floor_t            req_floor;
    } cmd_t;

    // one status word as held in the result register
    typedef struct packed {
        floor_t car_floor;
        logic   in_motion;
        logic   heading_up;
        logic   arrived;
    } status_t;

endpackage

[rtl/core/els_if.sv]
interface els_cmd_if;
    import els_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    floor_t            req_floor;

    modport source (output valid, output mode, output req_floor, input ready);
    modport sink   (input valid, input mode, input req_floor, output ready);
endinterface

interface els_status_if;
    import els_pkg::*;

    logic   valid;
    logic   ready;
    floor_t car_floor;
    logic   in_motion;
    logic   heading_up;
    logic   arrived;

    modport source (
        output valid, output car_floor, output in_motion, output heading_up,
        output arrived, input ready
    );
    modport sink (
        input valid, input car_floor, input in_motion, input heading_up,
        input arrived, output ready
    );
endinterface

[rtl/core/els_cmd_reg.sv]
module els_cmd_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  els_pkg::cmd_t in_word,
    input  logic          take,
    output logic          out_valid,
    output els_pkg::cmd_t out_word
);
    import els_pkg::*;

    logic valid_reg;
    cmd_t word_reg;

    // the register frees up in the same cycle the next stage takes its word
    assign in_ready  = !valid_reg || take;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

endmodule

[rtl/core/els_look_step.sv]
module els_look_step #(
    parameter int NUM_FLOORS = els_pkg::NUM_FLOORS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  els_pkg::cmd_t    word,
    output els_pkg::status_t result
);
    import els_pkg::*;

    localparam int POS_MIN = $clog2(NUM_FLOORS + 1);
    localparam int POS_W   = (POS_MIN > FLOOR_W) ? POS_MIN : FLOOR_W;
    localparam int IDX_W   = $clog2(NUM_FLOORS);

    logic [NUM_FLOORS-1:0] above_reg, above_next;
    logic [NUM_FLOORS-1:0] below_reg, below_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  dir_up_reg, dir_up_next;
    logic                  moving_reg, moving_next;
    logic                  arrived;

    logic [IDX_W-1:0]      lo_idx, hi_idx;
    logic                  a_any, b_any;
    logic [POS_W-1:0]      t_lo, t_hi;
    logic [POS_W-1:0]      pos_inc, pos_dec, pos_step;
    logic                  path_a, path_b, check_above;
    logic [NUM_FLOORS-1:0] above_clr, below_clr;
    logic                  hit_a, hit_b, tick_live;
    logic [POS_W-1:0]      f_pos;
    logic                  f_ok;
    logic [NUM_FLOORS-1:0] f_bit;

    // nearest target above: lowest set bit
    always_comb
    begin
        lo_idx = '0;
        for (int i = NUM_FLOORS - 1; i >= 0; i--)
        begin
            if (above_reg[i])
            begin
                lo_idx = IDX_W'(i);
            end
        end
    end

    // nearest target below: highest set bit
    always_comb
    begin
        hi_idx = '0;
        for (int i = 0; i < NUM_FLOORS; i++)
        begin
            if (below_reg[i])
            begin
                hi_idx = IDX_W'(i);
            end
        end
    end

    assign a_any = |above_reg;
    assign b_any = |below_reg;
    assign t_lo  = POS_W'(lo_idx) + POS_W'(1);
    assign t_hi  = POS_W'(hi_idx) + POS_W'(1);

    // one floor either way, held at the ends of the shaft
    assign pos_inc = (pos_reg < POS_W'(NUM_FLOORS)) ? pos_reg + POS_W'(1) : pos_reg;
    assign pos_dec = (pos_reg > POS_W'(1)) ? pos_reg - POS_W'(1) : pos_reg;

    // keep going the current way while its target is still ahead or here
    assign path_a      = a_any && (pos_reg <= t_lo);
    assign path_b      = b_any && (pos_reg >= t_hi);
    assign check_above = dir_up_reg ? path_a : !path_b;

    always_comb
    begin
        if (dir_up_reg)
        begin
            pos_step = path_a ? ((pos_reg < t_lo) ? pos_inc : pos_reg) : pos_dec;
        end
        else
        begin
            pos_step = path_b ? ((pos_reg > t_hi) ? pos_dec : pos_reg) : pos_inc;
        end
    end

    // arrival on the set being served
    assign above_clr = above_reg & ~({{(NUM_FLOORS-1){1'b0}}, 1'b1} << lo_idx);
    assign below_clr = below_reg & ~({{(NUM_FLOORS-1){1'b0}}, 1'b1} << hi_idx);
    assign hit_a     = check_above && a_any && (t_lo == pos_step);
    assign hit_b     = !check_above && b_any && (t_hi == pos_step);
    assign tick_live = moving_reg && (a_any || b_any);

    // floor request decode
    assign f_pos = POS_W'(word.req_floor);
    assign f_ok  = (f_pos != '0) && (f_pos <= POS_W'(NUM_FLOORS));
    assign f_bit = {{(NUM_FLOORS-1){1'b0}}, 1'b1} << IDX_W'(f_pos - POS_W'(1));

    // next state for the word in the input register
    always_comb
    begin
        above_next  = above_reg;
        below_next  = below_reg;
        pos_next    = pos_reg;
        dir_up_next = dir_up_reg;
        moving_next = moving_reg;
        arrived     = 1'b0;
        case (word.mode)
            MODE_REQUEST:
            begin
                if (f_ok && (f_pos > pos_reg))
                begin
                    above_next = above_reg | f_bit;
                end
                else if (f_ok && (f_pos < pos_reg))
                begin
                    below_next = below_reg | f_bit;
                end
            end
            MODE_DOOR_CLOSE:
            begin
                moving_next = 1'b1;
            end
            MODE_TICK:
            begin
                if (tick_live)
                begin
                    pos_next    = pos_step;
                    dir_up_next = check_above;
                    if (hit_a)
                    begin
                        above_next  = above_clr;
                        moving_next = 1'b0;
                        arrived     = 1'b1;
                        if (above_clr == '0)
                        begin
                            dir_up_next = 1'b0;
                        end
                    end
                    else if (hit_b)
                    begin
                        below_next  = below_clr;
                        moving_next = 1'b0;
                        arrived     = 1'b1;
                        if (below_clr == '0)
                        begin
                            dir_up_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                // unused code leaves everything as it is
            end
        endcase
    end

    // scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg  <= '0;
            below_reg  <= '0;
            pos_reg    <= POS_W'(1);
            dir_up_reg <= 1'b1;
            moving_reg <= 1'b0;
        end
        else if (step_en)
        begin
            above_reg  <= above_next;
            below_reg  <= below_next;
            pos_reg    <= pos_next;
            dir_up_reg <= dir_up_next;
            moving_reg <= moving_next;
        end
    end

    // status word after this command
    assign result.car_floor  = pos_next[FLOOR_W-1:0];
    assign result.in_motion  = moving_next;
    assign result.heading_up = dir_up_next;
    assign result.arrived    = arrived;

endmodule

[rtl/core/els_status_reg.sv]
module els_status_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             take,
    input  els_pkg::status_t in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output els_pkg::status_t out_word
);
    import els_pkg::*;

    logic    valid_reg;
    status_t word_reg;

    // load when empty or when the held word leaves this cycle
    assign take      = up_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= in_word;
        end
    end

endmodule

[rtl/core/elevator_look_scheduler_core.sv]
// LOOK scheduler for a single lift car.
// cmd channel: one word per event. mode selects a floor request (req_floor
// is the floor), a door close that lets the car move, or a movement tick.
// status channel: one word for every command word, in order, giving the car
// floor, the moving flag, the heading and whether the tick reached a target.
// Path: the edge that takes a command loads it into the command register,
// and a later edge that finds the status register free loads its status
// word there, where it holds until status.ready takes it.
// Throughput: one word per cycle while status.ready is high; the search for
// pending floors is two combinational priority encoders on the floor bits.
// Reset: both pending sets empty, car at floor 1, heading up, not moving,
// both registers empty.
// Stall: while status.ready is low the status word holds, one more command
// waits in the command register, and cmd.ready drops only when both are full.
module elevator_look_scheduler_core #(
    parameter int NUM_FLOORS = els_pkg::NUM_FLOORS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    els_cmd_if.sink            cmd,
    els_status_if.source       status
);
    import els_pkg::*;

    cmd_t    cmd_word, cmd_held;
    logic    cmd_held_valid;
    logic    take;
    status_t next_status, status_word;

    assign cmd_word.mode      = cmd.mode;
    assign cmd_word.req_floor = cmd.req_floor;

    // command register
    els_cmd_reg u_cmd_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .in_word   (cmd_word),
        .take      (take),
        .out_valid (cmd_held_valid),
        .out_word  (cmd_held)
    );

    // scheduler state and step logic
    els_look_step #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (take),
        .word    (cmd_held),
        .result  (next_status)
    );

    // status register
    els_status_reg u_status_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (cmd_held_valid),
        .take      (take),
        .in_word   (next_status),
        .out_valid (status.valid),
        .out_ready (status.ready),
        .out_word  (status_word)
    );

    assign status.car_floor  = status_word.car_floor;
    assign status.in_motion  = status_word.in_motion;
    assign status.heading_up = status_word.heading_up;
    assign status.arrived    = status_word.arrived;

endmodule

[rtl/core/els_checker.sv]
module els_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic                  st_valid,
    input logic                  st_ready,
    input logic [els_pkg::FLOOR_W-1:0] car_floor,
    input logic                  in_motion,
    input logic                  heading_up,
    input logic                  arrived
);
    import els_pkg::*;

    // an arrival always stops the car
    a_arrival_stops: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid |-> !(arrived && in_motion))
        else $error("status shows arrival while still moving");

    // a taken command reaches the status port if status.ready is high while it waits in the command register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) ##1 st_ready |=> st_valid)
        else $error("status word missing two cycles after command");

    // a stalled status word holds
    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid && !st_ready) |=> st_valid && $stable(car_floor)
            && $stable(in_motion) && $stable(heading_up) && $stable(arrived))
        else $error("stalled status word changed");

endmodule

bind elevator_look_scheduler_core els_checker u_els_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .st_valid   (status.valid),
    .st_ready   (status.ready),
    .car_floor  (status.car_floor),
    .in_motion  (status.in_motion),
    .heading_up (status.heading_up),
    .arrived    (status.arrived)
);
